// ===== rtl/fip_pkg.sv =====
// shared types and constants for the flywheel incremental pid block
// no dependencies; imported by every module of the block
package fip_pkg;

	localparam int MOTOR_W   = 12;
	localparam int CHAN_W    = 4;
	localparam int SPEED_W   = 16;
	localparam int ERR_W     = 17;
	localparam int DERIV_W   = 18;
	localparam int INTEG_W   = 32;
	localparam int DRIVE_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int DB_W      = 15;
	localparam int CMD_W     = 8;
	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 16;
	localparam int Q_DEPTH   = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_DEADBND = 3'd1,
		REG_KP      = 3'd2,
		REG_KI      = 3'd3,
		REG_KD      = 3'd4,
		REG_LEFT    = 3'd5,
		REG_RIGHT   = 3'd6,
		REG_REVERSE = 3'd7
	} fip_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTEG,
		ST_MUL,
		ST_SUM,
		ST_TOTAL,
		ST_CLAMP,
		ST_EMIT
	} fip_state_t;

	typedef struct packed {
		logic                      side;
		logic signed [SPEED_W-1:0] measured_speed;
	} fip_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0]       motor_channel;
		logic signed [CMD_W-1:0] motor_speed;
		logic                    last;
	} fip_out_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] target_speed;
		logic [DB_W-1:0]           deadband;
		logic [GAIN_W-1:0]         kp_gain;
		logic [GAIN_W-1:0]         ki_gain;
		logic [GAIN_W-1:0]         kd_gain;
		logic [MOTOR_W-1:0]        left_motor_mask;
		logic [MOTOR_W-1:0]        right_motor_mask;
		logic [MOTOR_W-1:0]        reverse_motor_mask;
	} fip_cfg_t;

	typedef struct packed {
		logic                    side;
		logic signed [ERR_W-1:0] err;
		logic                    update;
		logic                    in_window;
	} fip_item_t;

endpackage

// ===== rtl/fip_front.sv =====
// front end: accepts measurements, forms the error and classifies it
// depends on fip_pkg
module fip_front #(
	parameter int INTEGRAL_WINDOW = 3000
) (
	input  logic               meas_valid,
	output logic               meas_ready,
	input  fip_pkg::fip_in_t   meas,
	input  fip_pkg::fip_cfg_t  cfg,
	input  logic               q_full,
	output logic               q_push,
	output fip_pkg::fip_item_t q_item
);
	import fip_pkg::*;

	localparam logic [ERR_W-1:0] WINDOW = ERR_W'(INTEGRAL_WINDOW);

	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        mag;

	always_comb begin
		err = {cfg.target_speed[SPEED_W-1], cfg.target_speed}
			- {meas.measured_speed[SPEED_W-1], meas.measured_speed};
		mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		q_item.side      = meas.side;
		q_item.err       = err;
		q_item.update    = mag > {{(ERR_W-DB_W){1'b0}}, cfg.deadband};
		q_item.in_window = mag < WINDOW;
	end

	assign meas_ready = !q_full;
	assign q_push     = meas_valid && !q_full;

endmodule

// ===== rtl/fip_queue.sv =====
// short queue between the front end and the update engine
// depends on fip_pkg
module fip_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fip_pkg::fip_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               avail,
	output fip_pkg::fip_item_t pop_item
);
	import fip_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	fip_item_t         mem_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = count_q == CNT_W'(Q_DEPTH);
	assign avail    = count_q != '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fip_back.sv =====
// back end: per-side pid state update and serial channel fan-out
// depends on fip_pkg
module fip_back #(
	parameter int NUM_MOTORS  = 12,
	parameter int DRIVE_LIMIT = 127
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fip_pkg::fip_cfg_t  cfg,
	input  logic               q_avail,
	input  fip_pkg::fip_item_t q_item,
	output logic               q_pop,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output fip_pkg::fip_out_t  cmd
);
	import fip_pkg::*;

	localparam int CH    = (NUM_MOTORS < MOTOR_W) ? NUM_MOTORS : MOTOR_W;
	localparam int IDX_W = (CH > 1) ? $clog2(CH) : 1;
	localparam int PKP_W = GAIN_W + 1 + ERR_W;
	localparam int PKD_W = GAIN_W + 1 + DERIV_W;
	localparam int PKI_W = GAIN_W + 1 + INTEG_W;
	localparam int TW    = PKI_W + 2;
	localparam int QW    = TW - 16;
	localparam logic signed [QW-1:0] LIM = QW'(DRIVE_LIMIT);

	fip_state_t state_q, state_nx;

	fip_item_t                 cur_q;
	logic signed [INTEG_W-1:0] integ_q [2];
	logic signed [ERR_W-1:0]   prev_q  [2];
	logic signed [DRIVE_W-1:0] drive_q [2];
	logic signed [INTEG_W-1:0] integ_cur_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [PKP_W-1:0]   pkp_q;
	logic signed [PKD_W-1:0]   pkd_q;
	logic signed [PKI_W-1:0]   pki_q;
	logic signed [TW-1:0]      part_q;
	logic signed [TW-1:0]      total_q;
	logic [CH-1:0]             scan_q;
	fip_out_t                  out_q;
	logic                      out_valid_q;

	logic                      emit;
	logic                      out_free;
	logic signed [INTEG_W:0]   acc;
	logic signed [INTEG_W-1:0] integ_nx;
	logic signed [PKP_W-1:0]   mkp;
	logic signed [PKD_W-1:0]   mkd;
	logic signed [PKI_W-1:0]   mki;
	logic signed [DRIVE_W-1:0] drv;
	logic signed [QW-1:0]      quo;
	logic signed [QW-1:0]      quo_cl;
	logic [IDX_W-1:0]          idx;
	logic [CH-1:0]             scan_rest;
	logic [CH-1:0]             mask_pop;
	logic [CH-1:0]             mask_cur;
	logic signed [CMD_W-1:0]   drv8;

	assign out_free  = !out_valid_q || cmd_ready;
	assign cmd_valid = out_valid_q;
	assign cmd       = out_q;
	assign drv       = drive_q[cur_q.side];
	assign mask_pop  = q_item.side ? cfg.right_motor_mask[CH-1:0]
		: cfg.left_motor_mask[CH-1:0];
	assign mask_cur  = cur_q.side ? cfg.right_motor_mask[CH-1:0]
		: cfg.left_motor_mask[CH-1:0];

	always_comb begin
		acc = {integ_q[cur_q.side][INTEG_W-1], integ_q[cur_q.side]}
			+ {{(INTEG_W+1-ERR_W){cur_q.err[ERR_W-1]}}, cur_q.err};
		if (cfg.ki_gain == '0 || !cur_q.in_window) begin
			integ_nx = '0;
		end else if (acc[INTEG_W] != acc[INTEG_W-1]) begin
			integ_nx = acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_nx = acc[INTEG_W-1:0];
		end
		mkp = $signed({1'b0, cfg.kp_gain}) * cur_q.err;
		mkd = $signed({1'b0, cfg.kd_gain}) * deriv_q;
		mki = $signed({1'b0, cfg.ki_gain}) * integ_cur_q;
		quo = total_q[TW-1:16];
		if (total_q[TW-1] && (total_q[15:0] != '0)) begin
			quo = quo + 1'b1;
		end
		if (quo > LIM) begin
			quo_cl = LIM;
		end else if (quo < -LIM) begin
			quo_cl = -LIM;
		end else begin
			quo_cl = quo;
		end
	end

	// lowest pending channel first
	always_comb begin
		idx = '0;
		for (int i = CH - 1; i >= 0; i--) begin
			if (scan_q[i]) begin
				idx = IDX_W'(i);
			end
		end
		scan_rest      = scan_q;
		scan_rest[idx] = 1'b0;
		drv8           = drv[CMD_W-1:0];
	end

	always_comb begin
		state_nx = state_q;
		q_pop    = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_avail) begin
					q_pop    = 1'b1;
					state_nx = q_item.update ? ST_INTEG : ST_EMIT;
				end
			end
			ST_INTEG: state_nx = ST_MUL;
			ST_MUL:   state_nx = ST_SUM;
			ST_SUM:   state_nx = ST_TOTAL;
			ST_TOTAL: state_nx = ST_CLAMP;
			ST_CLAMP: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (scan_q == '0) begin
					state_nx = ST_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					if (scan_rest == '0) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '{default: '0};
			prev_q      <= '{default: '0};
			drive_q     <= '{default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_INTEG) begin
				integ_q[cur_q.side] <= integ_nx;
				prev_q[cur_q.side]  <= cur_q.err;
			end
			if (state_q == ST_CLAMP) begin
				drive_q[cur_q.side] <= DRIVE_W'(quo_cl);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (cmd_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_item;
			scan_q <= mask_pop;
		end
		if (state_q == ST_INTEG) begin
			integ_cur_q <= integ_nx;
			deriv_q     <= {cur_q.err[ERR_W-1], cur_q.err}
				- {prev_q[cur_q.side][ERR_W-1], prev_q[cur_q.side]};
		end
		if (state_q == ST_MUL) begin
			pkp_q <= mkp;
			pkd_q <= mkd;
			pki_q <= mki;
		end
		if (state_q == ST_SUM) begin
			part_q <= {{(TW-PKP_W){pkp_q[PKP_W-1]}}, pkp_q}
				+ {{(TW-PKD_W){pkd_q[PKD_W-1]}}, pkd_q}
				+ {{(TW-DRIVE_W-16){drv[DRIVE_W-1]}}, drv, 16'h0000};
		end
		if (state_q == ST_TOTAL) begin
			total_q <= part_q + {{(TW-PKI_W){pki_q[PKI_W-1]}}, pki_q};
		end
		if (state_q == ST_CLAMP) begin
			scan_q <= mask_cur;
		end
		if (emit) begin
			scan_q              <= scan_rest;
			out_q.motor_channel <= CHAN_W'(idx) + 1'b1;
			out_q.motor_speed   <= cfg.reverse_motor_mask[idx] ? -drv8 : drv8;
			out_q.last          <= scan_rest == '0;
		end
	end

endmodule

// ===== rtl/flywheel_incremental_pid.sv =====
// top level of the flywheel incremental pid controller
// depends on fip_pkg, fip_front, fip_queue, fip_back
//
// usage:
//   meas channel (valid/ready) carries one speed reading for the left or
//   right flywheel. each transaction updates that side's pid state when the
//   error leaves the deadband, then sends the side's drive to every channel
//   in the side's mask, lowest channel first, on the cmd channel
//   (valid/ready); last marks the final command of the update.
//   the write port (wr_en, wr_index, wr_data) sets one of the eight
//   registers per write; write it only while no update is in flight.
// update sequence:
//   an update steps through integ, mul, sum, total and clamp from the queue
//   head to the first command, then sends one command per cycle while cmd
//   is not held, for each channel in the mask (up to 12), all on the single
//   pid sequencer. a reading inside the deadband skips the arithmetic.
//   a two-entry queue lets readings be taken while the sequencer is busy.
// reset: all pid state and registers take their reset values at once.
// stall: a held cmd stops the fan-out; readings are taken until the
//   queue fills.
module flywheel_incremental_pid #(
	parameter int NUM_MOTORS      = 12,
	parameter int INTEGRAL_WINDOW = 3000,
	parameter int DRIVE_LIMIT     = 127
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              meas_valid,
	output logic                              meas_ready,
	input  fip_pkg::fip_in_t                  meas,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output fip_pkg::fip_out_t                 cmd,
	input  logic                              wr_en,
	input  logic [fip_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [fip_pkg::REG_DAT_W-1:0]     wr_data
);
	import fip_pkg::*;

	fip_cfg_t  cfg_q;
	fip_item_t push_item;
	fip_item_t pop_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed       <= '0;
			cfg_q.deadband           <= DB_W'(10);
			cfg_q.kp_gain            <= GAIN_W'(492);
			cfg_q.ki_gain            <= '0;
			cfg_q.kd_gain            <= GAIN_W'(82);
			cfg_q.left_motor_mask    <= '0;
			cfg_q.right_motor_mask   <= '0;
			cfg_q.reverse_motor_mask <= '0;
		end else if (wr_en) begin
			unique case (fip_reg_t'(wr_index))
				REG_TARGET:  cfg_q.target_speed       <= wr_data;
				REG_DEADBND: cfg_q.deadband           <= wr_data[DB_W-1:0];
				REG_KP:      cfg_q.kp_gain            <= wr_data;
				REG_KI:      cfg_q.ki_gain            <= wr_data;
				REG_KD:      cfg_q.kd_gain            <= wr_data;
				REG_LEFT:    cfg_q.left_motor_mask    <= wr_data[MOTOR_W-1:0];
				REG_RIGHT:   cfg_q.right_motor_mask   <= wr_data[MOTOR_W-1:0];
				REG_REVERSE: cfg_q.reverse_motor_mask <= wr_data[MOTOR_W-1:0];
				default: ;
			endcase
		end
	end

	fip_front #(
		.INTEGRAL_WINDOW(INTEGRAL_WINDOW)
	) u_front (
		.meas_valid(meas_valid),
		.meas_ready(meas_ready),
		.meas      (meas),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	fip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_item (pop_item)
	);

	fip_back #(
		.NUM_MOTORS (NUM_MOTORS),
		.DRIVE_LIMIT(DRIVE_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_avail  (q_avail),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

endmodule

// ===== rtl/fip_checker.sv =====
// port-level checks for flywheel_incremental_pid, attached with bind
// depends on fip_pkg and the top level's port list
module fip_port_checks (
	input logic              clk,
	input logic              arst_n,
	input logic              meas_valid,
	input logic              meas_ready,
	input fip_pkg::fip_in_t  meas,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input fip_pkg::fip_out_t cmd
);
	import fip_pkg::*;

	// waiting measurement holds
	a_meas_hold: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && !meas_ready |=> meas_valid && $stable(meas))
		else $error("measurement changed while waiting");

	// stalled command holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("cmd changed while stalled");

	// channel numbers stay in range
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd.motor_channel >= CHAN_W'(1)
			&& cmd.motor_channel <= CHAN_W'(MOTOR_W))
		else $error("channel out of range");

	// no command straight out of reset
	a_reset_idle: assert property (@(posedge clk)
		!$past(arst_n) |-> !cmd_valid)
		else $error("cmd valid right after reset");

endmodule

bind flywheel_incremental_pid fip_port_checks u_fip_port_checks (.*);
